@@ design/anchor_set_dedup_hash_store_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the anchor set dedup store
// Implication checks on the clk_i / rst_ni domain; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ANCHOR_SET_DEDUP_HASH_STORE_MACROS_SVH
`define ANCHOR_SET_DEDUP_HASH_STORE_MACROS_SVH

`ifndef SYNTHESIS
`define ASDHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("asdhs: same-cycle check failed");
`define ASDHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("asdhs: next-cycle check failed");
`else
`define ASDHS_ASSERT_IMP(lbl, ante, cons)
`define ASDHS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ design/asdhs_pkg.sv @@
// ----------------------------------------------------------------------------
// asdhs_pkg
// Command / result beat types, codes and sequencer states.
// ----------------------------------------------------------------------------
package asdhs_pkg;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_GET   = 2'd1,
    CMD_CLEAR = 2'd2
  } asdhs_cmd_e;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_GET_PAIR = 3'd3,
    ST_BAD_IDX  = 3'd4,
    ST_CLEARED  = 3'd5
  } asdhs_status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_H_LEN,
    S_H_I,
    S_H_K,
    S_B_CHK,
    S_K_RD,
    S_K_LEN,
    S_K_I,
    S_K_K,
    S_N_CHK,
    S_C_I,
    S_C_K,
    S_N_DONE,
    S_G_RD,
    S_G_LEN,
    S_G_I,
    S_G_K
  } asdhs_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  set_length;
    logic [19:0] pos_i;
    logic [19:0] pos_k;
    logic [9:0]  key_index;
    logic        last;
  } asdhs_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  result_index;
    logic [31:0] occurrences;
    logic [6:0]  out_length;
    logic [19:0] out_i;
    logic [19:0] out_k;
    logic        out_last;
  } asdhs_res_t;

endpackage

@@ design/asdhs_hash.sv @@
// ----------------------------------------------------------------------------
// asdhs_hash
// Shared hash accumulator: h = (h*33 + v) mod 2^r, one value per step.
// ----------------------------------------------------------------------------
module asdhs_hash #(
  parameter int HB_W       = 10,
  parameter int VALUE_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [3:0]            size_log2_i,
  input  logic                  step_i,
  input  logic                  init_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic [HB_W-1:0]       hash_o,
  output logic [HB_W-1:0]       hash_next_o
);

  localparam int EW = (HB_W > VALUE_BITS) ? HB_W : VALUE_BITS;

  logic [HB_W-1:0] hash_q, hash_d;
  logic [HB_W-1:0] base, mask, sum;
  logic [4:0]      r_eff;

  always_comb begin
    r_eff = (size_log2_i == 4'd0) ? 5'd1 : {1'b0, size_log2_i};
    if (int'(r_eff) > HB_W) begin
      r_eff = 5'(HB_W);
    end
    for (int i = 0; i < HB_W; i++) begin
      mask[i] = (i < int'(r_eff));
    end
  end

  always_comb begin
    base   = init_i ? '0 : hash_q;
    // times 33 as shift-add, only low bits survive the modulo
    sum    = HB_W'({base, 5'b0}) + base + HB_W'(EW'(value_i));
    hash_d = step_i ? (sum & mask) : hash_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign hash_o      = hash_q;
  assign hash_next_o = hash_d;

endmodule

@@ design/anchor_set_dedup_hash_store.sv @@
// ----------------------------------------------------------------------------
// anchor_set_dedup_hash_store
// Chained hash table that dedups anchor-pair sets and streams them back.
// ----------------------------------------------------------------------------
// Usage:
//  - Command beat on cmd_i, taken when start_i is high and busy_o low.
//  - Store: one beat per pair; the beat with last set ends the key and carries
//    no pair when set_length is zero. The final beat hashes every pair, walks
//    the bucket chain comparing each candidate key, then copies a new key.
//    One result: new, duplicate or full.
//  - Get: a key lookup, then one result beat per pair (a single beat for an empty key).
//  - Clear: sweeps all HASH_BUCKETS bucket entries, one per cycle, then
//    reports cleared. Bad index and overflowed stores answer straight from idle.
//  - Results appear on res_o for one cycle with res_valid_o; the receiver
//    cannot stall, so a result never blocks the next command.
//  - cfg_data_i (bucket count log2) is written while cfg_valid_i is high;
//    cfg_ready_o is always high.
//  - After reset the same bucket sweep runs with busy_o high and no result.
// ----------------------------------------------------------------------------
`include "anchor_set_dedup_hash_store_macros.svh"

module anchor_set_dedup_hash_store #(
  parameter int HASH_BUCKETS  = 1024,
  parameter int MAX_KEYS      = 1024,
  parameter int KEY_MEM_WORDS = 16384,
  parameter int MAX_ANCHORS   = 64,
  parameter int VALUE_BITS    = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  asdhs_pkg::asdhs_cmd_t cmd_i,
  output logic                  busy_o,
  output logic                  res_valid_o,
  output asdhs_pkg::asdhs_res_t res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [3:0]            cfg_data_i
);

  import asdhs_pkg::*;

  localparam int HB_W = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
  localparam int KA_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int KU_W = $clog2(MAX_KEYS + 1);
  localparam int WA_W = $clog2(KEY_MEM_WORDS);
  localparam int WU_W = $clog2(KEY_MEM_WORDS + 1);
  localparam int PA_W = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
  localparam int PC_W = $clog2(MAX_ANCHORS + 1);
  localparam int VB   = VALUE_BITS;

  // memories
  logic [KA_W:0]   bkt_mem   [HASH_BUCKETS];
  logic [KA_W:0]   nxt_mem   [MAX_KEYS];
  logic [WA_W-1:0] start_mem [MAX_KEYS];
  logic [31:0]     occ_mem   [MAX_KEYS];
  logic [VB-1:0]   kw_mem    [KEY_MEM_WORDS];
  logic [2*VB-1:0] pair_mem  [MAX_ANCHORS];

  logic [KA_W:0]   bkt_rd_q, nxt_rd_q;
  logic [WA_W-1:0] start_rd_q;
  logic [31:0]     occ_rd_q;
  logic [VB-1:0]   kw_rd_q;
  logic [2*VB-1:0] pair_rd_q;

  logic            bkt_we, key_we, occ_we, kw_we, pair_we;
  logic [HB_W-1:0] bkt_wa;
  logic [KA_W:0]   bkt_wd;
  logic [KA_W-1:0] key_wa, occ_wa;
  logic [31:0]     occ_wd;
  logic [WA_W-1:0] kw_wa;
  logic [VB-1:0]   kw_wd;
  logic [PA_W-1:0] pair_wa;
  logic [2*VB-1:0] pair_wd;

  asdhs_state_e state_q, state_d;
  logic [3:0]      cfg_q;
  logic [PC_W-1:0] pend_cnt_q, pend_cnt_d;
  logic            pend_ov_q, pend_ov_d;
  logic [KU_W-1:0] keys_q, keys_d, steps_q, steps_d;
  logic [WU_W-1:0] words_q, words_d;
  logic [KA_W-1:0] idx_q, idx_d;
  logic [WA_W-1:0] w_q, w_d;
  logic [PC_W-1:0] p_q, p_d, glen_q, glen_d;
  logic [VB-1:0]   vi_q, vi_d;
  logic [HB_W-1:0] clr_cnt_q, clr_cnt_d;
  logic            clr_emit_q, clr_emit_d;
  asdhs_res_t      res_q, res_d;
  logic            res_valid_q, res_valid_d;

  logic            hash_step, hash_init;
  logic [VB-1:0]   hash_val;
  logic [HB_W-1:0] hash, hash_next;

  asdhs_hash #(
    .HB_W       (HB_W),
    .VALUE_BITS (VB)
  ) u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_log2_i (cfg_q),
    .step_i      (hash_step),
    .init_i      (hash_init),
    .value_i     (hash_val),
    .hash_o      (hash),
    .hash_next_o (hash_next)
  );

  // shared conditions
  logic            accept, do_app, cnt_full, ov_next, last_pair, last_get;
  logic            room, bad_idx, clr_last;
  logic [PC_W-1:0] cnt_next;
  logic [19:0]     vmask;
  logic [VB-1:0]   in_vi, in_vk, pi, pk, d_word;
  logic [WU_W:0]   need;

  always_comb begin
    for (int i = 0; i < 20; i++) begin
      vmask[i] = (i < VB);
    end
    in_vi     = VB'(cmd_i.pos_i & vmask);
    in_vk     = VB'(cmd_i.pos_k & vmask);
    accept    = start_i && (state_q == S_IDLE);
    do_app    = !cmd_i.last || (cmd_i.set_length != 7'd0);
    cnt_full  = (pend_cnt_q == PC_W'(MAX_ANCHORS));
    cnt_next  = (do_app && !cnt_full) ? PC_W'(pend_cnt_q + 1'b1) : pend_cnt_q;
    ov_next   = pend_ov_q || (do_app && cnt_full);
    pi        = pair_rd_q[2*VB-1:VB];
    pk        = pair_rd_q[VB-1:0];
    d_word    = VB'(pend_cnt_q);
    last_pair = (PC_W'(p_q + 1'b1) == pend_cnt_q);
    last_get  = (PC_W'(p_q + 1'b1) == glen_q);
    need      = (WU_W+1)'({pend_cnt_q, 1'b1});
    room      = (keys_q < KU_W'(MAX_KEYS)) &&
                ((WU_W+1)'(words_q) + need <= (WU_W+1)'(KEY_MEM_WORDS));
    bad_idx   = int'(cmd_i.key_index) >= int'(keys_q);
    clr_last  = (clr_cnt_q == HB_W'(HASH_BUCKETS - 1));
  end

  function automatic asdhs_res_t mk_res(asdhs_status_e st, logic [KA_W-1:0] idx,
                                        logic [31:0] occ, logic [PC_W-1:0] len,
                                        logic [VB-1:0] vi, logic [VB-1:0] vk,
                                        logic lst);
    asdhs_res_t r;
    r.status       = st;
    r.result_index = 10'(idx);
    r.occurrences  = occ;
    r.out_length   = 7'(len);
    r.out_i        = 20'(vi);
    r.out_k        = 20'(vk);
    r.out_last     = lst;
    return r;
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i.command)
            CMD_STORE: state_d = (cmd_i.last && !ov_next) ? S_H_LEN : S_IDLE;
            CMD_GET:   state_d = bad_idx ? S_IDLE : S_G_RD;
            CMD_CLEAR: state_d = S_CLR;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_CLR:    state_d = clr_last ? S_IDLE : S_CLR;
      S_H_LEN:  state_d = (pend_cnt_q == '0) ? S_B_CHK : S_H_I;
      S_H_I:    state_d = S_H_K;
      S_H_K:    state_d = last_pair ? S_B_CHK : S_H_I;
      S_B_CHK:  state_d = (bkt_rd_q[KA_W] && (steps_q < keys_q)) ? S_K_RD : S_N_CHK;
      S_K_RD:   state_d = S_K_LEN;
      S_K_LEN, S_K_I, S_K_K: begin
        priority if ((state_q == S_K_LEN && kw_rd_q == d_word && pend_cnt_q == '0) ||
                     (state_q == S_K_K && kw_rd_q == pk && last_pair)) begin
          state_d = S_IDLE;
        end else if (state_q == S_K_LEN && kw_rd_q == d_word) begin
          state_d = S_K_I;
        end else if (state_q == S_K_I && kw_rd_q == pi) begin
          state_d = S_K_K;
        end else if (state_q == S_K_K && kw_rd_q == pk) begin
          state_d = S_K_I;
        end else begin
          state_d = (nxt_rd_q[KA_W] && (steps_q < keys_q)) ? S_K_RD : S_N_CHK;
        end
      end
      S_N_CHK: begin
        priority if (!room)              state_d = S_IDLE;
        else if (pend_cnt_q == '0)       state_d = S_N_DONE;
        else                             state_d = S_C_I;
      end
      S_C_I:    state_d = S_C_K;
      S_C_K:    state_d = last_pair ? S_N_DONE : S_C_I;
      S_N_DONE: state_d = S_IDLE;
      S_G_RD:   state_d = S_G_LEN;
      S_G_LEN:  state_d = (kw_rd_q == '0) ? S_IDLE : S_G_I;
      S_G_I:    state_d = S_G_K;
      S_G_K:    state_d = last_get ? S_IDLE : S_G_I;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pend_cnt_d  = pend_cnt_q;
    pend_ov_d   = pend_ov_q;
    keys_d      = keys_q;
    words_d     = words_q;
    steps_d     = steps_q;
    idx_d       = idx_q;
    w_d         = w_q;
    p_d         = p_q;
    glen_d      = glen_q;
    vi_d        = vi_q;
    clr_cnt_d   = clr_cnt_q;
    clr_emit_d  = clr_emit_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    hash_step   = 1'b0;
    hash_init   = 1'b0;
    hash_val    = '0;
    bkt_we      = 1'b0;
    bkt_wa      = hash;
    bkt_wd      = {1'b1, idx_q};
    key_we      = 1'b0;
    key_wa      = KA_W'(keys_q);
    occ_we      = 1'b0;
    occ_wa      = idx_q;
    occ_wd      = (occ_rd_q == '1) ? occ_rd_q : occ_rd_q + 32'd1;
    kw_we       = 1'b0;
    kw_wa       = w_q;
    kw_wd       = pi;
    pair_we     = 1'b0;
    pair_wa     = pend_cnt_q[PA_W-1:0];
    pair_wd     = {in_vi, in_vk};

    unique case (state_q)
      S_IDLE: begin
        p_d     = '0;
        steps_d = '0;
        if (accept) begin
          unique case (cmd_i.command)
            CMD_STORE: begin
              pair_we    = do_app && !cnt_full;
              pend_cnt_d = cnt_next;
              pend_ov_d  = ov_next;
              if (cmd_i.last && ov_next) begin
                res_d       = mk_res(ST_FULL, '0, '0, cnt_next, '0, '0, 1'b1);
                res_valid_d = 1'b1;
                pend_cnt_d  = '0;
                pend_ov_d   = 1'b0;
              end
            end
            CMD_GET: begin
              idx_d = KA_W'(cmd_i.key_index);
              if (bad_idx) begin
                res_d       = mk_res(ST_BAD_IDX, '0, '0, '0, '0, '0, 1'b1);
                res_valid_d = 1'b1;
              end
            end
            CMD_CLEAR: begin
              keys_d     = '0;
              words_d    = '0;
              pend_cnt_d = '0;
              pend_ov_d  = 1'b0;
              clr_cnt_d  = '0;
              clr_emit_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        bkt_we    = 1'b1;
        bkt_wa    = clr_cnt_q;
        bkt_wd    = '0;
        clr_cnt_d = HB_W'(clr_cnt_q + 1'b1);
        if (clr_last) begin
          clr_emit_d = 1'b0;
          if (clr_emit_q) begin
            res_d       = mk_res(ST_CLEARED, '0, '0, '0, '0, '0, 1'b1);
            res_valid_d = 1'b1;
          end
        end
      end
      S_H_LEN: begin
        hash_step = 1'b1;
        hash_init = 1'b1;
        hash_val  = d_word;
      end
      S_H_I: begin
        hash_step = 1'b1;
        hash_val  = pi;
      end
      S_H_K: begin
        hash_step = 1'b1;
        hash_val  = pk;
        p_d       = PC_W'(p_q + 1'b1);
      end
      S_B_CHK: begin
        idx_d = bkt_rd_q[KA_W-1:0];
      end
      S_K_RD: begin
        w_d     = start_rd_q;
        steps_d = KU_W'(steps_q + 1'b1);
      end
      S_K_LEN, S_K_I, S_K_K: begin
        priority if ((state_q == S_K_LEN && kw_rd_q == d_word && pend_cnt_q == '0) ||
                     (state_q == S_K_K && kw_rd_q == pk && last_pair)) begin
          occ_we      = 1'b1;
          res_d       = mk_res(ST_DUP, idx_q, occ_wd, pend_cnt_q, '0, '0, 1'b1);
          res_valid_d = 1'b1;
          pend_cnt_d  = '0;
          pend_ov_d   = 1'b0;
        end else if (state_q == S_K_LEN && kw_rd_q == d_word) begin
          w_d = WA_W'(w_q + 1'b1);
          p_d = '0;
        end else if (state_q == S_K_I && kw_rd_q == pi) begin
          w_d = WA_W'(w_q + 1'b1);
        end else if (state_q == S_K_K && kw_rd_q == pk) begin
          w_d = WA_W'(w_q + 1'b1);
          p_d = PC_W'(p_q + 1'b1);
        end else begin
          // mismatch: follow the chain
          idx_d = nxt_rd_q[KA_W-1:0];
          p_d   = '0;
        end
      end
      S_N_CHK: begin
        if (!room) begin
          res_d       = mk_res(ST_FULL, '0, '0, pend_cnt_q, '0, '0, 1'b1);
          res_valid_d = 1'b1;
          pend_cnt_d  = '0;
          pend_ov_d   = 1'b0;
        end else begin
          key_we = 1'b1;
          bkt_we = 1'b1;
          bkt_wd = {1'b1, KA_W'(keys_q)};
          kw_we  = 1'b1;
          kw_wa  = WA_W'(words_q);
          kw_wd  = d_word;
          w_d    = WA_W'(words_q + 1'b1);
          p_d    = '0;
        end
      end
      S_C_I: begin
        kw_we = 1'b1;
        kw_wd = pi;
        w_d   = WA_W'(w_q + 1'b1);
      end
      S_C_K: begin
        kw_we = 1'b1;
        kw_wd = pk;
        w_d   = WA_W'(w_q + 1'b1);
        p_d   = PC_W'(p_q + 1'b1);
      end
      S_N_DONE: begin
        res_d       = mk_res(ST_NEW, KA_W'(keys_q), 32'd1, pend_cnt_q, '0, '0, 1'b1);
        res_valid_d = 1'b1;
        keys_d      = KU_W'(keys_q + 1'b1);
        words_d     = WU_W'((WU_W+1)'(words_q) + need);
        pend_cnt_d  = '0;
        pend_ov_d   = 1'b0;
      end
      S_G_RD: begin
        w_d = start_rd_q;
      end
      S_G_LEN: begin
        glen_d = PC_W'(kw_rd_q);
        w_d    = WA_W'(w_q + 1'b1);
        p_d    = '0;
        if (kw_rd_q == '0) begin
          res_d       = mk_res(ST_GET_PAIR, idx_q, occ_rd_q, '0, '0, '0, 1'b1);
          res_valid_d = 1'b1;
        end
      end
      S_G_I: begin
        vi_d = kw_rd_q;
        w_d  = WA_W'(w_q + 1'b1);
      end
      S_G_K: begin
        res_d       = mk_res(ST_GET_PAIR, idx_q, occ_rd_q, glen_q, vi_q, kw_rd_q,
                             last_get);
        res_valid_d = 1'b1;
        w_d         = WA_W'(w_q + 1'b1);
        p_d         = PC_W'(p_q + 1'b1);
      end
      default: ;
    endcase
  end

  // memories: one write, one registered read each; reads follow next-cycle address
  always_ff @(posedge clk_i) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    bkt_rd_q <= bkt_mem[hash_next];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      nxt_mem[key_wa]   <= bkt_rd_q;
      start_mem[key_wa] <= WA_W'(words_q);
      occ_mem[key_wa]   <= 32'd1;
    end else if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    nxt_rd_q   <= nxt_mem[idx_d];
    start_rd_q <= start_mem[idx_d];
    occ_rd_q   <= occ_mem[idx_d];
  end

  always_ff @(posedge clk_i) begin
    if (kw_we) kw_mem[kw_wa] <= kw_wd;
    kw_rd_q <= kw_mem[w_d];
  end

  always_ff @(posedge clk_i) begin
    if (pair_we) pair_mem[pair_wa] <= pair_wd;
    pair_rd_q <= pair_mem[p_d[PA_W-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    w_q    <= w_d;
    p_q    <= p_d;
    glen_q <= glen_d;
    vi_q   <= vi_d;
    res_q  <= res_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cfg_q       <= 4'd7;
      pend_cnt_q  <= '0;
      pend_ov_q   <= 1'b0;
      keys_q      <= '0;
      words_q     <= '0;
      steps_q     <= '0;
      clr_cnt_q   <= '0;
      clr_emit_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      pend_cnt_q  <= pend_cnt_d;
      pend_ov_q   <= pend_ov_d;
      keys_q      <= keys_d;
      words_q     <= words_d;
      steps_q     <= steps_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_emit_q  <= clr_emit_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

  `ASDHS_ASSERT_IMP(a_single_beat_last, res_valid_q && res_q.status != ST_GET_PAIR, res_q.out_last)
  `ASDHS_ASSERT_NXT(a_clear_sweeps, accept && cmd_i.command == CMD_CLEAR, state_q == S_CLR && keys_q == '0)
  `ASDHS_ASSERT_IMP(a_no_result_in_sweep, state_q == S_CLR, !res_valid_q)
  `ASDHS_ASSERT_IMP(a_counts_bounded, 1'b1, keys_q <= KU_W'(MAX_KEYS) && pend_cnt_q <= PC_W'(MAX_ANCHORS))

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives store, get and clear commands into the anchor set dedup store and
// checks every result beat against a behavioral copy of the hash table.
// ----------------------------------------------------------------------------
class dedup_scoreboard;
  asdhs_pkg::asdhs_res_t exp_q[$];
  int unsigned           errors;

  // table copy
  bit [3:0]    log2_sz;
  bit          bkt_valid[1024];
  bit [9:0]    bkt_head[1024];
  bit          nxt_valid[1024];
  bit [9:0]    nxt_idx[1024];
  int unsigned kstart[1024];
  bit [31:0]   kocc[1024];
  bit [19:0]   kmem[16384];
  bit [19:0]   pend[128];
  int unsigned pend_n;
  bit          pend_ovf;
  int unsigned nkeys;
  int unsigned nwords;

  function new();
    log2_sz = 4'd7;
    nkeys   = 0;
    nwords  = 0;
    pend_n  = 0;
    pend_ovf = 0;
    errors  = 0;
    foreach (bkt_valid[j]) bkt_valid[j] = 0;
  endfunction

  function void push(bit [2:0] st, bit [9:0] idx, bit [31:0] occ, bit [6:0] len,
                     bit [19:0] vi, bit [19:0] vk, bit lst);
    asdhs_pkg::asdhs_res_t r;
    r.status = st; r.result_index = idx; r.occurrences = occ;
    r.out_length = len; r.out_i = vi; r.out_k = vk; r.out_last = lst;
    exp_q.push_back(r);
  endfunction

  function void add_pair(bit [19:0] vi, bit [19:0] vk);
    if (pend_n < 64) begin
      pend[2*pend_n] = vi;
      pend[2*pend_n+1] = vk;
      pend_n++;
    end else begin
      pend_ovf = 1;
    end
  endfunction

  function void finish_store();
    int unsigned d, nb, h, steps, s, need, j;
    bit          vld, eq;
    bit [9:0]    idx;
    d = pend_n;
    if (pend_ovf) begin
      pend_n = 0; pend_ovf = 0;
      push(asdhs_pkg::ST_FULL, 0, 0, 7'(d), 0, 0, 1);
      return;
    end
    nb = 1 << ((log2_sz == 0) ? 1 : log2_sz);
    if (nb > 1024) nb = 1024;
    h = d % nb;
    for (j = 0; j < 2*d; j++) h = (h*33 + pend[j]) % nb;
    vld = bkt_valid[h];
    idx = bkt_head[h];
    for (steps = 0; vld && steps < nkeys; steps++) begin
      s = kstart[idx];
      eq = (kmem[s] == d);
      for (j = 0; eq && j < 2*d; j++) if (kmem[s+1+j] != pend[j]) eq = 0;
      if (eq) begin
        if (kocc[idx] != 32'hFFFF_FFFF) kocc[idx]++;
        pend_n = 0;
        push(asdhs_pkg::ST_DUP, idx, kocc[idx], 7'(d), 0, 0, 1);
        return;
      end
      vld = nxt_valid[idx];
      idx = nxt_idx[idx];
    end
    need = 2*d + 1;
    pend_n = 0;
    if (nkeys >= 1024 || nwords + need > 16384) begin
      push(asdhs_pkg::ST_FULL, 0, 0, 7'(d), 0, 0, 1);
      return;
    end
    kstart[nkeys] = nwords;
    kocc[nkeys] = 1;
    kmem[nwords] = 20'(d);
    for (j = 0; j < 2*d; j++) kmem[nwords+1+j] = pend[j];
    nwords += need;
    nxt_valid[nkeys] = bkt_valid[h];
    nxt_idx[nkeys] = bkt_head[h];
    bkt_valid[h] = 1;
    bkt_head[h] = 10'(nkeys);
    push(asdhs_pkg::ST_NEW, 10'(nkeys), 1, 7'(d), 0, 0, 1);
    nkeys++;
  endfunction

  // note one accepted command beat
  function void note_cmd(asdhs_pkg::asdhs_cmd_t c);
    int unsigned s, d, p;
    case (c.command)
      asdhs_pkg::CMD_STORE: begin
        if (!c.last) add_pair(c.pos_i, c.pos_k);
        else begin
          if (c.set_length != 0) add_pair(c.pos_i, c.pos_k);
          finish_store();
        end
      end
      asdhs_pkg::CMD_GET: begin
        if (c.key_index >= nkeys) begin
          push(asdhs_pkg::ST_BAD_IDX, 0, 0, 0, 0, 0, 1);
        end else begin
          s = kstart[c.key_index];
          d = kmem[s];
          if (d == 0) push(asdhs_pkg::ST_GET_PAIR, c.key_index, kocc[c.key_index], 0, 0, 0, 1);
          for (p = 0; p < d; p++)
            push(asdhs_pkg::ST_GET_PAIR, c.key_index, kocc[c.key_index], 7'(d),
                 kmem[s+1+2*p], kmem[s+2+2*p], p + 1 == d);
        end
      end
      asdhs_pkg::CMD_CLEAR: begin
        foreach (bkt_valid[j]) bkt_valid[j] = 0;
        nkeys = 0; nwords = 0; pend_n = 0; pend_ovf = 0;
        push(asdhs_pkg::ST_CLEARED, 0, 0, 0, 0, 0, 1);
      end
      default: ;
    endcase
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_res(asdhs_pkg::asdhs_res_t got);
    asdhs_pkg::asdhs_res_t e;
    if (exp_q.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    e = exp_q.pop_front();
    if (got.status != e.status) report($sformatf("status %0d exp %0d", got.status, e.status));
    if (got.result_index != e.result_index)
      report($sformatf("index %0d exp %0d", got.result_index, e.result_index));
    if (got.occurrences != e.occurrences)
      report($sformatf("occ %0d exp %0d", got.occurrences, e.occurrences));
    if (got.out_length != e.out_length)
      report($sformatf("length %0d exp %0d", got.out_length, e.out_length));
    if (got.out_i != e.out_i) report($sformatf("out_i %h exp %h", got.out_i, e.out_i));
    if (got.out_k != e.out_k) report($sformatf("out_k %h exp %h", got.out_k, e.out_k));
    if (got.out_last != e.out_last) report($sformatf("last %0d exp %0d", got.out_last, e.out_last));
  endtask
endclass

module tb_top;
  import asdhs_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  // command code the block ignores
  localparam bit [1:0] CMD_NONE = 2'd3;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       start_i = 0;
  asdhs_cmd_t cmd_i = '0;
  logic       busy_o;
  logic       res_valid_o;
  asdhs_res_t res_o;
  logic       cfg_valid_i = 0;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i = '0;

  dedup_scoreboard sb = new();
  int unsigned     cycles = 0;
  bit              no_gaps = 0;
  bit [19:0]       lib_i[4][8];
  bit [19:0]       lib_k[4][8];
  int unsigned     lib_len[4];

  anchor_set_dedup_hash_store u_top (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_o, .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (res_valid_o) sb.check_res(res_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // start_i stays high after a beat so the next one can follow at once
  task automatic send(bit [1:0] c, bit [6:0] len, bit [19:0] vi, bit [19:0] vk,
                      bit [9:0] kidx, bit lst);
    asdhs_cmd_t b;
    int unsigned g;
    if (!no_gaps && $urandom_range(3) == 0) begin
      g = $urandom_range(19, 1);
      start_i <= 0;
      cmd_i <= asdhs_cmd_t'(60'({$urandom, $urandom}));
      repeat (g) @(posedge clk_i);
    end
    b.command = c; b.set_length = len; b.pos_i = vi; b.pos_k = vk;
    b.key_index = kidx; b.last = lst;
    start_i <= 1;
    cmd_i <= b;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_cmd(b);
  endtask

  // one key of n pairs; empty key when n is zero
  task automatic store_key(int unsigned n, bit rnd_vals, int unsigned lib);
    bit [19:0] vi, vk;
    if (n == 0) begin
      send(CMD_STORE, 0, 20'($urandom), 20'($urandom), 10'($urandom), 1);
      return;
    end
    for (int unsigned p = 0; p < n; p++) begin
      vi = rnd_vals ? 20'($urandom) : lib_i[lib][p];
      vk = rnd_vals ? 20'($urandom) : lib_k[lib][p];
      send(CMD_STORE, (p + 1 == n) ? 7'($urandom_range(64, 1)) : 7'($urandom),
           vi, vk, 10'($urandom), p + 1 == n);
    end
  endtask

  task automatic settle();
    start_i <= 0;
    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
  endtask

  task automatic write_cfg(bit [3:0] v);
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.log2_sz = v;
    cfg_valid_i <= 0;
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned r, l;
    for (int unsigned t = 0; t < n; t++) begin
      r = $urandom_range(99);
      l = $urandom_range(3);
      if (r < 45) store_key(lib_len[l], 0, l);
      else if (r < 65) store_key($urandom_range(6), 1, 0);
      else if (r < 85) send(CMD_GET, 7'($urandom), 20'($urandom), 20'($urandom),
                            ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(12)),
                            1'($urandom));
      else if (r < 90) send(CMD_CLEAR, 7'($urandom), 20'($urandom), 20'($urandom),
                            10'($urandom), 1'($urandom));
      else if (r < 95) send(CMD_NONE, 7'($urandom), 20'($urandom), 20'($urandom),
                            10'($urandom), 1'($urandom));
      else send(CMD_STORE, 0, 20'($urandom), 20'($urandom), 10'($urandom), 1);
    end
  endtask

  initial begin
    for (int l = 0; l < 4; l++) begin
      lib_len[l] = $urandom_range(5, 1);
      for (int p = 0; p < 8; p++) begin
        lib_i[l][p] = 20'($urandom);
        lib_k[l][p] = 20'($urandom);
      end
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    settle();
    // directed
    store_key(0, 1, 0);
    store_key(0, 1, 0);
    send(CMD_STORE, 7'd64, 20'hFFFFF, 20'hFFFFF, 0, 1);
    send(CMD_STORE, 7'd1, 20'h00000, 20'hFFFFF, 0, 1);
    send(CMD_STORE, 7'd64, 20'hFFFFF, 20'hFFFFF, 0, 1);
    send(CMD_GET, 0, 0, 0, 10'd0, 0);
    send(CMD_GET, 0, 0, 0, 10'd1, 0);
    send(CMD_GET, 0, 0, 0, 10'd1023, 0);
    send(CMD_STORE, 0, 20'h12345, 20'h54321, 0, 0);
    send(CMD_GET, 0, 0, 0, 10'd1, 0);
    send(CMD_STORE, 7'd5, 20'h0AAAA, 20'h05555, 0, 1);
    send(CMD_NONE, 7'h7F, 20'hFFFFF, 20'hFFFFF, 10'h3FF, 1);
    store_key(65, 1, 0);
    send(CMD_GET, 0, 0, 0, 10'd3, 0);
    send(CMD_STORE, 0, 20'h1, 20'h2, 0, 0);
    send(CMD_CLEAR, 0, 0, 0, 0, 0);
    send(CMD_GET, 0, 0, 0, 10'd0, 0);
    settle();
    write_cfg(4'd1);
    random_phase(4);
    settle();
    write_cfg(4'd0);
    random_phase(3);
    settle();
    write_cfg(4'd15);
    random_phase(4);
    settle();
    write_cfg(4'd10);
    random_phase(3);
    settle();
    write_cfg(4'd4);
    no_gaps = 1;
    random_phase(4);
    settle();
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
